// File: rtl/fixed_point_q24_8_alu_macros.svh
// assertion macros for the q24.8 alu
// used by modules that check their own logic; expects clk and rst_n in scope
`ifndef FIXED_POINT_Q24_8_ALU_MACROS_SVH
`define FIXED_POINT_Q24_8_ALU_MACROS_SVH

// same-cycle implication
`define FPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/fpa_pkg.sv
// types, codes and helpers shared by the q24.8 alu
// no dependencies
`default_nettype none
package fpa_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 8;
  localparam int NUM_W  = WORD_W + FRAC_W;

  localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_GT, MODE_LT, MODE_GE, MODE_LE,
    MODE_EQ, MODE_NE, MODE_MIN, MODE_MAX, MODE_INC, MODE_DEC, MODE_TOINT, MODE_FROMINT
  } fpa_mode_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  // partial result carried down the divider row
  typedef struct packed {
    logic [WORD_W-1:0] result;
    logic              cmp;
    logic [1:0]        status;
    logic              is_div;
    logic              neg;
  } fpa_pre_t;

  // one divider cell's contents
  typedef struct packed {
    logic              valid;
    fpa_pre_t          pre;
    logic [NUM_W-1:0]  num;
    logic [WORD_W-1:0] rem;
    logic [NUM_W-1:0]  quo;
    logic [WORD_W-1:0] den;
  } fpa_div_t;

  typedef struct packed {
    logic              ovf;
    logic [WORD_W-1:0] word;
  } fpa_sat_t;

  // absolute value as unsigned, most negative maps to 2^31
  function automatic logic [WORD_W-1:0] fpa_mag(input logic [WORD_W-1:0] v);
    fpa_mag = v[WORD_W-1] ? (~v + 1'b1) : v;
  endfunction

  // sign and magnitude to word, saturating
  function automatic fpa_sat_t fpa_pack(input logic neg, input logic [63:0] mag);
    fpa_sat_t s;
    logic [63:0] lim;
    lim = neg ? {32'd0, WORD_MIN} : {32'd0, WORD_MAX};
    if (mag > lim) begin
      s.ovf  = 1'b1;
      s.word = neg ? WORD_MIN : WORD_MAX;
    end else begin
      s.ovf  = 1'b0;
      s.word = neg ? (~mag[WORD_W-1:0] + 1'b1) : mag[WORD_W-1:0];
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// File: rtl/fpa_in_if.sv
// input channel: opcode and two raw q24.8 operands
// no dependencies
`default_nettype none
interface fpa_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [31:0] operand_a;
  logic [31:0] operand_b;

  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface
`default_nettype wire

// File: rtl/fpa_out_if.sv
// result channel: raw result, compare flag and status
// no dependencies
`default_nettype none
interface fpa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  logic        compare_true;
  logic [1:0]  status;

  modport source (output valid, result, compare_true, status, input ready);
  modport sink   (input valid, result, compare_true, status, output ready);
endinterface
`default_nettype wire

// File: rtl/fpa_front.sv
// front stages: simple ops and multiply, then divider setup
// depends on fpa_pkg
`default_nettype none
module fpa_front import fpa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [3:0]        in_mode,
  input  wire logic [WORD_W-1:0] in_a,
  input  wire logic [WORD_W-1:0] in_b,
  output fpa_div_t               head
);

  logic              s1_valid_r;
  fpa_pre_t          s1_pre_r, s1_pre_nxt;
  logic              s1_mul_r;
  logic [WORD_W-1:0] s1_x_r, s1_y_r;
  logic [63:0]       s1_p_r;
  fpa_div_t          head_r, head_nxt;

  logic [WORD_W-1:0] xa, yb, sum, dif, inc, dec, mabs_sh;
  logic [WORD_W:0]   toint_t;
  logic [WORD_W-1:0] lim_int;
  logic              lt, eq, neg;
  logic [63:0]       mul_rnd;
  fpa_sat_t          mul_s;

  // stage 1 decode
  always_comb begin
    xa   = fpa_mag(in_a);
    yb   = fpa_mag(in_b);
    neg  = in_a[WORD_W-1];
    sum  = in_a + in_b;
    dif  = in_a - in_b;
    inc  = in_a + 32'd1;
    dec  = in_a - 32'd1;
    lt   = $signed(in_a) < $signed(in_b);
    eq   = in_a == in_b;
    toint_t = ({1'b0, xa} + 33'd128) >> FRAC_W;
    lim_int = neg ? 32'h0080_0000 : 32'h007F_FFFF;
    mabs_sh = xa << FRAC_W;
    s1_pre_nxt = '0;
    s1_pre_nxt.status = ST_OK;
    case (fpa_mode_t'(in_mode))
      MODE_ADD: begin
        s1_pre_nxt.result = sum;
        if (in_a[31] == in_b[31] && sum[31] != in_a[31]) begin
          s1_pre_nxt.status = ST_OVF;
          s1_pre_nxt.result = in_a[31] ? WORD_MIN : WORD_MAX;
        end
      end
      MODE_SUB: begin
        s1_pre_nxt.result = dif;
        if (in_a[31] != in_b[31] && dif[31] != in_a[31]) begin
          s1_pre_nxt.status = ST_OVF;
          s1_pre_nxt.result = in_a[31] ? WORD_MIN : WORD_MAX;
        end
      end
      MODE_MUL: s1_pre_nxt.neg = in_a[31] ^ in_b[31];
      MODE_DIV: begin
        s1_pre_nxt.is_div = 1'b1;
        s1_pre_nxt.neg    = in_a[31] ^ in_b[31];
      end
      MODE_GT:  s1_pre_nxt.cmp = !lt && !eq;
      MODE_LT:  s1_pre_nxt.cmp = lt;
      MODE_GE:  s1_pre_nxt.cmp = !lt;
      MODE_LE:  s1_pre_nxt.cmp = lt || eq;
      MODE_EQ:  s1_pre_nxt.cmp = eq;
      MODE_NE:  s1_pre_nxt.cmp = !eq;
      MODE_MIN: s1_pre_nxt.result = (lt || eq) ? in_a : in_b;
      MODE_MAX: s1_pre_nxt.result = !lt ? in_a : in_b;
      MODE_INC: begin
        s1_pre_nxt.result = inc;
        if (!in_a[31] && inc[31]) begin
          s1_pre_nxt.status = ST_OVF;
          s1_pre_nxt.result = WORD_MAX;
        end
      end
      MODE_DEC: begin
        s1_pre_nxt.result = dec;
        if (in_a[31] && !dec[31]) begin
          s1_pre_nxt.status = ST_OVF;
          s1_pre_nxt.result = WORD_MIN;
        end
      end
      MODE_TOINT: s1_pre_nxt.result = neg ? (~toint_t[WORD_W-1:0] + 1'b1)
                                          : toint_t[WORD_W-1:0];
      MODE_FROMINT: begin
        if (xa > lim_int) begin
          s1_pre_nxt.status = ST_OVF;
          s1_pre_nxt.result = neg ? WORD_MIN : WORD_MAX;
        end else begin
          s1_pre_nxt.result = neg ? (~mabs_sh + 1'b1) : mabs_sh;
        end
      end
      default: s1_pre_nxt = '0;
    endcase
  end

  // stage 1 registers, product of magnitudes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pre_r <= s1_pre_nxt;
      s1_mul_r <= in_mode == MODE_MUL;
      s1_x_r   <= xa;
      s1_y_r   <= yb;
      s1_p_r   <= xa * yb;
    end
  end

  // stage 2 multiply rounding and divider setup
  always_comb begin
    mul_rnd = (s1_p_r + 64'd128) >> FRAC_W;
    mul_s   = fpa_pack(s1_pre_r.neg, mul_rnd);
    head_nxt.valid = s1_valid_r;
    head_nxt.pre   = s1_pre_r;
    if (s1_mul_r) begin
      head_nxt.pre.result = mul_s.word;
      head_nxt.pre.status = mul_s.ovf ? ST_OVF : ST_OK;
    end
    head_nxt.num = {s1_x_r, {FRAC_W{1'b0}}};
    head_nxt.rem = '0;
    head_nxt.quo = '0;
    head_nxt.den = s1_y_r;
  end

  // head of the divider row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.valid <= 1'b0;
    end else if (en) begin
      head_r.valid <= head_nxt.valid;
    end
    if (en) begin
      head_r.pre <= head_nxt.pre;
      head_r.num <= head_nxt.num;
      head_r.rem <= head_nxt.rem;
      head_r.quo <= head_nxt.quo;
      head_r.den <= head_nxt.den;
    end
  end

  assign head = head_r;

endmodule
`default_nettype wire

// File: rtl/fpa_div_cell.sv
// one restoring-divide cell: one quotient bit per cell
// depends on fpa_pkg
`default_nettype none
module fpa_div_cell import fpa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  fpa_div_t  cin,
  output fpa_div_t  cout
);

  fpa_div_t          cell_r, cell_nxt;
  logic [WORD_W:0]   rem_sh;
  logic              qbit;

  // shift in next dividend bit, trial subtract
  always_comb begin
    rem_sh   = {cin.rem, cin.num[NUM_W-1]};
    qbit     = rem_sh >= {1'b0, cin.den};
    cell_nxt = cin;
    cell_nxt.num = cin.num << 1;
    cell_nxt.rem = qbit ? (rem_sh[WORD_W-1:0] - cin.den) : rem_sh[WORD_W-1:0];
    cell_nxt.quo = {cin.quo[NUM_W-2:0], qbit};
  end

  // cell register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r.valid <= cell_nxt.valid;
    end
    if (en) begin
      cell_r.pre <= cell_nxt.pre;
      cell_r.num <= cell_nxt.num;
      cell_r.rem <= cell_nxt.rem;
      cell_r.quo <= cell_nxt.quo;
      cell_r.den <= cell_nxt.den;
    end
  end

  assign cout = cell_r;

endmodule
`default_nettype wire

// File: rtl/fpa_back.sv
// quotient rounding, final select and output register
// depends on fpa_pkg
`default_nettype none
module fpa_back import fpa_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  fpa_div_t                tail,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [WORD_W-1:0]       out_result,
  output logic                    out_cmp,
  output logic [1:0]              out_status,
  output logic                    en
);

  logic              out_valid_r;
  logic [WORD_W-1:0] result_r, result_nxt;
  logic              cmp_r;
  logic [1:0]        status_r, status_nxt;
  logic              rnd_up, load;
  logic [NUM_W:0]    q_rnd;
  fpa_sat_t          div_s;

  // round half away from zero on the remainder, then saturate
  always_comb begin
    rnd_up = {tail.rem, 1'b0} >= {1'b0, tail.den};
    q_rnd  = {1'b0, tail.quo} + {{NUM_W{1'b0}}, rnd_up};
    div_s  = fpa_pack(tail.pre.neg, {{(63-NUM_W){1'b0}}, q_rnd});
    result_nxt = tail.pre.result;
    status_nxt = tail.pre.status;
    if (tail.pre.is_div) begin
      if (tail.den == '0) begin
        result_nxt = '0;
        status_nxt = ST_DIVZ;
      end else begin
        result_nxt = div_s.word;
        status_nxt = div_s.ovf ? ST_OVF : ST_OK;
      end
    end
  end

  // row stalls only when a held beat would be overwritten
  assign load = out_ready || !out_valid_r;
  assign en   = load || !tail.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_nxt;
      cmp_r    <= tail.pre.cmp;
      status_r <= status_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = result_r;
  assign out_cmp    = cmp_r;
  assign out_status = status_r;

endmodule
`default_nettype wire

// File: rtl/fixed_point_q24_8_alu.sv
// Signed Q24.8 ALU, one beat in and one beat out per cycle, fully pipelined.
// Every beat passes from input to output register through two front stages
// (decode, simple ops and a 32x32 magnitude multiply, then multiply rounding),
// a row of 40 divider cells that each settle one quotient bit, and the output
// register. All opcodes run the same path so beats leave in order. The row
// stalls only while the output register holds an untaken beat and the last
// cell holds another; otherwise in_ch.ready stays high.
// depends on fpa_pkg, fpa_in_if, fpa_out_if, fpa_front, fpa_div_cell, fpa_back
`include "fixed_point_q24_8_alu_macros.svh"
`default_nettype none
module fixed_point_q24_8_alu import fpa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  fpa_in_if.sink    in_ch,
  fpa_out_if.source out_ch
);

  fpa_div_t row [0:NUM_W];
  logic     en;

  // front stages
  fpa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_a     (in_ch.operand_a),
    .in_b     (in_ch.operand_b),
    .head     (row[0])
  );

  // divider cell row
  for (genvar k = 0; k < NUM_W; k++) begin : g_cell
    fpa_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .cin   (row[k]),
      .cout  (row[k+1])
    );
  end

  // output stage
  fpa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .tail       (row[NUM_W]),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_result (out_ch.result),
    .out_cmp    (out_ch.compare_true),
    .out_status (out_ch.status),
    .en         (en)
  );

  assign in_ch.ready = en;

  // checks
  `FPA_ASSERT_IMP(a_cmp_clean, out_ch.valid && out_ch.compare_true, out_ch.result == '0 && out_ch.status == ST_OK, "compare beat carries a result or status")
  `FPA_ASSERT_IMP(a_divz_zero, out_ch.valid && out_ch.status == ST_DIVZ, out_ch.result == '0 && !out_ch.compare_true, "divide by zero beat not zero")
  `FPA_ASSERT_IMP(a_status_code, out_ch.valid, out_ch.status != 2'd3, "undefined status code")
  `FPA_ASSERT_IMP(a_stall_cause, !in_ch.ready, out_ch.valid && !out_ch.ready, "input stalled without output backpressure")
  `FPA_ASSERT_IMP(a_ovf_sat, out_ch.valid && out_ch.status == ST_OVF, out_ch.result == WORD_MAX || out_ch.result == WORD_MIN, "overflow beat not saturated")
  `FPA_ASSERT_NXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.result), "held result beat changed")

endmodule
`default_nettype wire
